### rtl/asmt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// asmt_pkg
// Shared types and codes for the address set membership table.
// ============================================================================
package asmt_pkg;

    localparam int ADDR_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    // Search token handed from one cell to the next.
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [ADDR_W-1:0] key;
    } t_link;

    // Write request broadcast to the cells; the target position travels apart.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] data;
    } t_wr;

endpackage

### rtl/asmt_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// asmt_cell
// One storage cell of the table: holds one address and passes the search
// token on to its neighbour, merging in its own compare result.
// ============================================================================
module asmt_cell
    import asmt_pkg::*;
#(
    parameter int POS   = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_link            i_link,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr              i_wr,
    input  logic [IDX_W-1:0] i_wr_idx,
    output t_link            o_link
);

    logic [ADDR_W-1:0] r_entry;
    logic              r_vld;
    logic              r_hit;
    logic [ADDR_W-1:0] r_key;
    logic              w_held;
    logic              w_match;

    // The entry only counts while its position lies below the fill count.
    assign w_held  = (CNT_W'(POS) < i_count);
    assign w_match = w_held && (r_entry == i_link.key);

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == IDX_W'(POS))) begin
            r_entry <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= i_link.hit | w_match;
        r_key <= i_link.key;
    end

    assign o_link = '{vld: r_vld, hit: r_hit, key: r_key};

endmodule

### rtl/address_set_membership_table_core.sv
`timescale 1ns / 1ps
// ============================================================================
// address_set_membership_table_core
// Fixed-capacity set of 32-bit addresses with add, membership test and clear.
// ============================================================================
// An item is taken when start is high and busy is low, and every item gives
// exactly one result, shown for a single cycle while o_done is high; the
// receiver cannot stall, so it must capture the result in that cycle. An add
// or a membership test sends a search token down a chain of CAPACITY cells,
// one cell per clock, so busy stays high while the token is in the chain,
// o_done rises once the token has left the last cell, and the next item can
// be taken in that same cycle, so a new add or test waits until the last is through.
// A clear or an unused command does not search, and its result comes on the
// next cycle. Reset empties the set by clearing the entry count; the stored
// addresses themselves are never cleared, as only positions below the entry
// count take part in a compare.
// ============================================================================
module address_set_membership_table_core
    import asmt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [ADDR_W-1:0]   i_address,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_hit,
    output logic [CNT_OUT_W-1:0] o_entry_count
);

    // Width of a cell position and of the fill count, which can reach CAPACITY.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state r_state;
    t_state n_state;

    logic [CMD_W-1:0]    r_cmd;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_done;
    logic                n_done;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                r_hit;
    logic                n_hit;

    logic                w_accept;
    logic                w_search_cmd;
    logic                w_inject;
    logic                w_full;
    t_wr                 w_wr;
    logic [CNT_W+CNT_OUT_W-1:0] w_count_ext;

    // The link array: entry k feeds cell k, the last entry leaves the chain.
    t_link w_link [0:CAPACITY];

    assign w_accept = start && !busy;

    // Only an add or a membership test has to search the table.
    always_comb begin
        unique case (i_command) inside
            CMD_ADD, CMD_CONTAINS: w_search_cmd = 1'b1;
            default:               w_search_cmd = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_search_cmd) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_link[CAPACITY].vld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        busy     = 1'b0;
        w_inject = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_inject = start && w_search_cmd;
            end
            S_SEARCH: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. The token carries the address with it, so the address
    // arriving at the end of the chain is the one to store on an add.
    // ------------------------------------------------------------------
    assign w_link[0] = '{vld: w_inject, hit: 1'b0, key: i_address};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        asmt_cell #(
            .POS   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_link   (w_link[g]),
            .i_count  (r_count),
            .i_wr     (w_wr),
            .i_wr_idx (r_count[IDX_W-1:0]),
            .o_link   (w_link[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Result and fill count. An item without a search answers at once; a
    // search answers on the cycle its token leaves the last cell.
    // ------------------------------------------------------------------
    assign w_full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_done   = 1'b0;
        n_status = r_status;
        n_hit    = r_hit;
        n_count  = r_count;
        w_wr.en   = 1'b0;
        w_wr.data = w_link[CAPACITY].key;
        if (w_accept && !w_search_cmd) begin
            n_done   = 1'b1;
            n_status = ST_DONE;
            n_hit    = 1'b0;
            if (i_command == CMD_CLEAR) begin
                n_count = '0;
            end
        end else if ((r_state == S_SEARCH) && w_link[CAPACITY].vld) begin
            n_done = 1'b1;
            n_hit  = w_link[CAPACITY].hit;
            if (r_cmd == CMD_ADD) begin
                if (w_link[CAPACITY].hit) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_ADDED;
                    n_count  = r_count + CNT_W'(1);
                    w_wr.en  = 1'b1;
                end
            end else begin
                n_status = ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hit    <= n_hit;
        if (w_accept) begin
            r_cmd <= i_command;
        end
    end

    // The count port carries the low bits of the count for large tables.
    assign w_count_ext   = {{CNT_OUT_W{1'b0}}, r_count};
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_hit         = r_hit;
    assign o_entry_count = w_count_ext[CNT_OUT_W-1:0];

`ifndef SYNTHESIS
    a_exit_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[CAPACITY].vld |-> (r_state == S_SEARCH))
        else $error("search token left the chain outside a search");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_search_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEARCH) && w_link[CAPACITY].vld) |=> o_done)
        else $error("finished search gave no result");

    a_count_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> o_done)
        else $error("fill count changed without a result");
`endif

endmodule
